### rtl/srisc_pkg.sv
`default_nettype none

package srisc_pkg;

  localparam int ADDR_W = 11;
  localparam int DATA_W = 32;
  localparam int RIDX_W = 5;
  localparam int IMM_W  = 18;
  localparam int SH_W   = 13;
  localparam int TGT_W  = 28;

  localparam logic [DATA_W-1:0] HALT_WORD = 32'hFFFF_FFFF;
  // magnitude of the most negative immediate
  localparam int IMM_NEG = 131072;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_EXEC  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    OPC_ADD  = 4'd0,
    OPC_SUB  = 4'd1,
    OPC_MUL  = 4'd2,
    OPC_MOVI = 4'd3,
    OPC_JEQ  = 4'd4,
    OPC_AND  = 4'd5,
    OPC_XORI = 4'd6,
    OPC_JMP  = 4'd7,
    OPC_LSL  = 4'd8,
    OPC_LSR  = 4'd9,
    OPC_MOVR = 4'd10,
    OPC_MOVM = 4'd11
  } opc_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDWAIT,
    ST_DECODE,
    ST_OPND,
    ST_EXEC,
    ST_MEM,
    ST_LOAD,
    ST_WRAP,
    ST_DONE
  } st_t;

endpackage

`default_nettype wire

### rtl/srisc_req_if.sv
`default_nettype none

interface srisc_req_if import srisc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic [ADDR_W-1:0]        address;
  logic signed [DATA_W-1:0] write_data;

  modport source(output valid, output operation, output address, output write_data,
                 input ready);
  modport sink(input valid, input operation, input address, input write_data,
               output ready);
endinterface

`default_nettype wire

### rtl/srisc_rsp_if.sv
`default_nettype none

interface srisc_rsp_if import srisc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_data;
  logic [ADDR_W-1:0]        pc_after;
  logic                     halted;
  logic                     reg_write;
  logic [RIDX_W-1:0]        reg_index;
  logic signed [DATA_W-1:0] reg_value;
  logic                     mem_write;
  logic [ADDR_W-1:0]        mem_address;
  logic                     bad_opcode;
  logic                     bad_address;

  modport source(output valid, output read_data, output pc_after, output halted,
                 output reg_write, output reg_index, output reg_value, output mem_write,
                 output mem_address, output bad_opcode, output bad_address, input ready);
  modport sink(input valid, input read_data, input pc_after, input halted,
               input reg_write, input reg_index, input reg_value, input mem_write,
               input mem_address, input bad_opcode, input bad_address, output ready);
endinterface

`default_nettype wire

### rtl/small_risc_core_step.sv
`default_nettype none
// Multicycle core, one item at a time; ready only in idle. States from accept to result valid:
// write, unknown op, bad-address read, execute while halted: done; read: read wait; execute:
// decode (halt word ends there), operand, execute, then mem for an in-range store, mem and load
// for a load, wrap for a taken jump if MEM_WORDS is not a power of two (reciprocal multiply).
// One shared memory port (fetch, load, store), one ALU. Reset (sync, active high) clears PC,
// halt flag and register valid bits, then zeroes all MEM_WORDS words; no beat is accepted meanwhile.
module small_risc_core_step import srisc_pkg::*; #(
  parameter int MEM_WORDS  = 2048,
  parameter int PROG_WORDS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  srisc_req_if.sink    req,
  srisc_rsp_if.source  rsp
);

  localparam int  AW     = $clog2(MEM_WORDS);
  localparam bit  POW2   = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
  localparam int  TW     = TGT_W;
  localparam int  KSH    = TW + AW;
  localparam int  OFFSET = MEM_WORDS * ((IMM_NEG + MEM_WORDS - 1) / MEM_WORDS);
  // ceil(2^KSH / MEM_WORDS): quotient is exact for any TW-bit value
  localparam logic [TW:0] RCP =
    (TW+1)'(((64'd1 << KSH) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS));

  st_t state, state_next;

  // control
  logic [AW-1:0] clr;
  logic [AW-1:0] pc;
  logic          halt;
  logic [31:0]   rf_vld;

  // datapath
  logic [31:0]   ins, vb, vc, va, res, rdata;
  logic [TW-1:0] t, quo, quo_m;
  logic [2*TW:0] rcp_prod;
  logic          wrap_ph;
  logic [AW-1:0] da_idx;
  logic [ADDR_W-1:0] maddr;
  logic          wr, redirect, mw, badop, badaddr, is_exec, halt_hit;

  // memories
  logic [31:0]   mem [MEM_WORDS];
  logic [AW-1:0] mem_a;
  logic          mem_we;
  logic [31:0]   mem_d, mem_q;
  logic [31:0]   regs [32];
  logic [4:0]    rf_ra, rf_rb, rf_wa;
  logic          rf_we;
  logic [31:0]   rf_qa, rf_qb;

  logic          accept, out_free, addr_ok;
  logic [AW-1:0] addr_idx, seq_pc, pc_new;
  logic          halt_new;

  // decode and ALU
  opc_t          opc;
  logic [4:0]    ra;
  logic [SH_W-1:0] sh;
  logic [31:0]   imm32, y, prod, alu_res;
  logic [32:0]   sum;
  logic          cin, alu_wr, alu_jump, alu_bad, is_ldst, in_mem, bad_da;
  logic [TW-1:0] t_new;

  assign accept   = req.valid && req.ready;
  assign out_free = !rsp.valid || rsp.ready;
  assign addr_ok  = 32'(req.address) < MEM_WORDS;
  assign addr_idx = AW'(32'(req.address));
  assign req.ready = (state == ST_IDLE);

  assign opc   = opc_t'(ins[31:28]);
  assign ra    = ins[27:23];
  assign sh    = ins[SH_W-1:0];
  assign imm32 = {{(DATA_W-IMM_W){ins[IMM_W-1]}}, ins[IMM_W-1:0]};
  assign prod  = vb * vc;
  assign is_ldst = (opc == OPC_MOVR) || (opc == OPC_MOVM);

  // jump target wrap: quotient by reciprocal, then subtract quotient * MEM_WORDS
  assign rcp_prod = (2*TW+1)'(t) * (2*TW+1)'(RCP);
  assign quo_m    = quo * TW'(MEM_WORDS);

  always_comb begin
    y   = imm32;
    cin = 1'b0;
    if (opc == OPC_ADD) begin
      y = vc;
    end else if (opc == OPC_SUB) begin
      y   = ~vc;
      cin = 1'b1;
    end
    sum = {vb[31], vb} + {y[31], y} + 33'(cin);
  end

  assign in_mem = !sum[32] && (sum < 33'(MEM_WORDS));
  assign bad_da = !in_mem || (sum < 33'(PROG_WORDS));

  always_comb begin
    alu_res  = '0;
    alu_wr   = 1'b0;
    alu_jump = 1'b0;
    alu_bad  = 1'b0;
    t_new    = TW'(32'(pc) + 32'd1) + TW'(imm32) + TW'(OFFSET);
    case (opc)
      OPC_ADD, OPC_SUB: begin
        alu_res = sum[31:0];
        alu_wr  = 1'b1;
      end
      OPC_MUL: begin
        alu_res = prod;
        alu_wr  = 1'b1;
      end
      OPC_MOVI: begin
        alu_res = imm32;
        alu_wr  = 1'b1;
      end
      OPC_JEQ: alu_jump = (rf_qa == vb);
      OPC_AND: begin
        alu_res = vb & vc;
        alu_wr  = 1'b1;
      end
      OPC_XORI: begin
        alu_res = vb ^ imm32;
        alu_wr  = 1'b1;
      end
      OPC_JMP: begin
        alu_jump = 1'b1;
        t_new    = ins[TW-1:0];
      end
      OPC_LSL: begin
        alu_res = (sh < SH_W'(32)) ? (vb << sh[4:0]) : '0;
        alu_wr  = 1'b1;
      end
      OPC_LSR: begin
        alu_res = (sh < SH_W'(32)) ? (vb >> sh[4:0]) : '0;
        alu_wr  = 1'b1;
      end
      OPC_MOVR, OPC_MOVM: alu_res = '0;
      default: alu_bad = 1'b1;
    endcase
  end

  assign seq_pc   = (pc == AW'(MEM_WORDS - 1)) ? '0 : pc + AW'(1);
  assign pc_new   = is_exec ? (redirect ? t[AW-1:0] : seq_pc) : pc;
  assign halt_new = halt || halt_hit
                    || (is_exec && !redirect && (32'(pc) >= PROG_WORDS - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr == AW'(MEM_WORDS - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(req.operation))
            OP_WRITE: state_next = ST_DONE;
            OP_READ:  state_next = addr_ok ? ST_RDWAIT : ST_DONE;
            OP_EXEC:  state_next = halt ? ST_DONE : ST_DECODE;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_RDWAIT: state_next = ST_DONE;
      ST_DECODE: state_next = (mem_q == HALT_WORD) ? ST_DONE : ST_OPND;
      ST_OPND:   state_next = ST_EXEC;
      ST_EXEC: begin
        if (is_ldst && in_mem) state_next = ST_MEM;
        else if (alu_jump && !POW2) state_next = ST_WRAP;
        else state_next = ST_DONE;
      end
      ST_MEM:  state_next = (opc == OPC_MOVR) ? ST_LOAD : ST_DONE;
      ST_LOAD: state_next = ST_DONE;
      ST_WRAP: if (wrap_ph) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory and register file ports
  always_comb begin
    mem_a  = pc;
    mem_we = 1'b0;
    mem_d  = va;
    rf_ra  = ra;
    rf_rb  = ins[17:13];
    case (state)
      ST_CLEAR: begin
        mem_a  = clr;
        mem_we = 1'b1;
        mem_d  = '0;
      end
      ST_IDLE: begin
        if (req.operation != OP_EXEC) begin
          mem_a  = addr_idx;
          mem_d  = req.write_data;
          mem_we = accept && (req.operation == OP_WRITE) && addr_ok;
        end
      end
      ST_DECODE: begin
        rf_ra = mem_q[22:18];
        rf_rb = mem_q[17:13];
      end
      ST_MEM: begin
        mem_a  = da_idx;
        mem_we = (opc == OPC_MOVM);
      end
      default: mem_a = pc;
    endcase
  end

  assign rf_we = (state == ST_DONE) && out_free && is_exec && wr && (ra != '0);
  assign rf_wa = ra;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_a] <= mem_d;
    mem_q <= mem[mem_a];
  end

  always_ff @(posedge clk) begin
    if (rf_we) regs[rf_wa] <= res;
    rf_qa <= rf_vld[rf_ra] ? regs[rf_ra] : '0;
    rf_qb <= rf_vld[rf_rb] ? regs[rf_rb] : '0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      pc        <= '0;
      halt      <= 1'b0;
      rf_vld    <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr <= clr + AW'(1);
      if (rf_we) rf_vld[rf_wa] <= 1'b1;
      if (state == ST_DONE && out_free) begin
        pc        <= pc_new;
        halt      <= halt_new;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          rdata    <= '0;
          mw       <= (req.operation == OP_WRITE) && addr_ok;
          maddr    <= ((req.operation == OP_WRITE) && addr_ok) ? req.address : '0;
          badop    <= 1'b0;
          badaddr  <= 1'b0;
          wr       <= 1'b0;
          redirect <= 1'b0;
          is_exec  <= 1'b0;
          halt_hit <= 1'b0;
        end
      end
      ST_RDWAIT: rdata <= mem_q;
      ST_DECODE: begin
        ins <= mem_q;
        if (mem_q == HALT_WORD) halt_hit <= 1'b1;
        else is_exec <= 1'b1;
      end
      ST_OPND: begin
        vb <= rf_qa;
        vc <= rf_qb;
      end
      ST_EXEC: begin
        va       <= rf_qa;
        res      <= alu_res;
        wr       <= alu_wr;
        redirect <= alu_jump;
        badop    <= alu_bad;
        t        <= t_new;
        wrap_ph  <= 1'b0;
        if (is_ldst) begin
          maddr   <= sum[ADDR_W-1:0];
          badaddr <= bad_da;
          da_idx  <= sum[AW-1:0];
        end
      end
      ST_MEM: if (opc == OPC_MOVM) mw <= 1'b1;
      ST_LOAD: begin
        res <= mem_q;
        wr  <= 1'b1;
      end
      ST_WRAP: begin
        if (!wrap_ph) quo <= TW'(rcp_prod >> KSH);
        else t <= t - quo_m;
        wrap_ph <= 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          rsp.read_data   <= rdata;
          rsp.pc_after    <= ADDR_W'(32'(pc_new));
          rsp.halted      <= halt_new;
          rsp.reg_write   <= is_exec && wr && (ra != '0);
          rsp.reg_index   <= (is_exec && wr) ? ra : '0;
          rsp.reg_value   <= (is_exec && wr && (ra != '0)) ? res : '0;
          rsp.mem_write   <= mw;
          rsp.mem_address <= maddr;
          rsp.bad_opcode  <= badop;
          rsp.bad_address <= badaddr;
        end
      end
      default: ;
    endcase
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) halt |=> halt)
    else $error("halt flag dropped");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    32'(pc) < MEM_WORDS)
    else $error("pc outside memory");

  a_mem_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR || state == ST_IDLE || state == ST_MEM))
    else $error("memory write outside access states");

  a_bad_op_quiet: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.bad_opcode) |-> (!rsp.reg_write && !rsp.mem_write))
    else $error("bad opcode beat changed state");

  a_r0_never: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.reg_write) |-> (rsp.reg_index != '0))
    else $error("write reported to r0");

endmodule

`default_nettype wire
